FILE: hdl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, codes and the segment table of the two-wire display driver
// ----------------------------------------------------------------------------
package ssd_pkg;

    // opcodes carried in the input tuser field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ASCII = 2'd1;
    localparam logic [1:0] OP_RAW   = 2'd2;

    // frame numbers within one transfer
    localparam logic [1:0] FRAME_CMD  = 2'd0;
    localparam logic [1:0] FRAME_DATA = 2'd1;
    localparam logic [1:0] FRAME_CTRL = 2'd2;

    // protocol bytes
    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
    localparam logic [7:0] CMD_DISP_BASE  = 8'h80;
    localparam logic [7:0] CMD_DISP_ON    = 8'h08;

    localparam logic [7:0] CHAR_FIRST = 8'h30;
    localparam logic [7:0] CHAR_LAST  = 8'h40;

    localparam logic [7:0] SEG_TABLE [17] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71,
        8'h00
    };

    typedef struct packed {
        logic tick;
        logic start;
    } seq_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic clk;
        logic dio;
    } seq_status_t;

    function automatic logic char_mapped(input logic [7:0] ch);
        return (ch >= CHAR_FIRST) && (ch <= CHAR_LAST);
    endfunction

    function automatic logic [7:0] seg_lookup(input logic [7:0] ch);
        logic [7:0] offs;
        offs = ch - CHAR_FIRST;
        if (char_mapped(ch))
        begin
            return SEG_TABLE[offs[4:0]];
        end
        return 8'h00;
    endfunction

endpackage

FILE: hdl/ssd_buffer.sv
// ----------------------------------------------------------------------------
// ssd_buffer
// digit buffer: stores pushed segment bytes and the start grid address
// ----------------------------------------------------------------------------
module ssd_buffer #(
    parameter int MAX_DIGITS = 6,
    parameter int CNT_W      = 3,
    parameter int IDX_W      = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  logic             push_raw,
    input  logic [7:0]       value,
    input  logic [2:0]       position,
    input  logic             clear,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_data,
    output logic [CNT_W-1:0] count,
    output logic [2:0]       start_pos,
    output logic             full
);

    logic [7:0]       store_reg [MAX_DIGITS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [2:0]       pos_reg;
    logic [7:0]       seg;
    logic             write_en;

    assign full     = (count_reg >= CNT_W'(MAX_DIGITS));
    assign write_en = push_en && !full;
    assign seg      = push_raw ? value : ssd_pkg::seg_lookup(value);

    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (write_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (write_en && (count_reg == '0))
            begin
                pos_reg <= position;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= seg;
        end
    end

    assign rd_data   = store_reg[rd_idx];
    assign count     = count_reg;
    assign start_pos = pos_reg;

endmodule

FILE: hdl/ssd_seq.sv
// ----------------------------------------------------------------------------
// ssd_seq
// pin phase sequencer: walks start, byte bits with ack, and stop of each frame
// ----------------------------------------------------------------------------
module ssd_seq #(
    parameter int CNT_W = 3,
    parameter int IDX_W = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssd_pkg::seq_ctrl_t     ctrl,
    input  logic [2:0]             brightness,
    input  logic [CNT_W-1:0]       count,
    input  logic [2:0]             start_pos,
    input  logic [7:0]             rd_data,
    output logic [IDX_W-1:0]       rd_idx,
    output ssd_pkg::seq_status_t   status
);

    typedef enum logic [2:0] {
        SEG_START = 3'b001,
        SEG_BODY  = 3'b010,
        SEG_STOP  = 3'b100
    } frame_seg_t;

    localparam logic [4:0] BIT_PHASES = 5'd16;
    localparam logic [4:0] ACK_HIGH   = 5'd17;

    frame_seg_t       seg_reg,    seg_next;
    logic [4:0]       cnt_reg,    cnt_next;
    logic [CNT_W-1:0] byte_reg,   byte_next;
    logic [1:0]       frame_reg,  frame_next;
    logic             active_reg, active_next;
    logic             clk_reg,    clk_next;
    logic             dio_reg,    dio_next;
    logic             done;
    logic [7:0]       frame_byte;
    logic [CNT_W-1:0] last_byte;
    logic [CNT_W-1:0] byte_m1;

    assign byte_m1   = byte_reg - 1'b1;
    assign rd_idx    = byte_m1[IDX_W-1:0];
    assign last_byte = (frame_reg == ssd_pkg::FRAME_DATA) ? count : '0;

    always_comb
    begin
        unique case (frame_reg)
            ssd_pkg::FRAME_CMD:
            begin
                frame_byte = ssd_pkg::CMD_DATA_WRITE;
            end
            ssd_pkg::FRAME_DATA:
            begin
                frame_byte = (byte_reg == '0) ?
                             (ssd_pkg::CMD_ADDR_BASE | {5'b0, start_pos}) : rd_data;
            end
            ssd_pkg::FRAME_CTRL:
            begin
                frame_byte = ssd_pkg::CMD_DISP_BASE | ssd_pkg::CMD_DISP_ON |
                             {5'b0, brightness};
            end
            default:
            begin
                frame_byte = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        seg_next    = seg_reg;
        cnt_next    = cnt_reg;
        byte_next   = byte_reg;
        frame_next  = frame_reg;
        active_next = active_reg;
        clk_next    = clk_reg;
        dio_next    = dio_reg;
        done        = 1'b0;
        if (ctrl.start)
        begin
            active_next = 1'b1;
            seg_next    = SEG_START;
            cnt_next    = '0;
            byte_next   = '0;
            frame_next  = ssd_pkg::FRAME_CMD;
        end
        else if (ctrl.tick && active_reg)
        begin
            unique case (seg_reg)
                SEG_START:
                begin
                    clk_next = 1'b1;
                    dio_next = (cnt_reg == '0);
                    if (cnt_reg == 5'd1)
                    begin
                        seg_next  = SEG_BODY;
                        cnt_next  = '0;
                        byte_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                SEG_BODY:
                begin
                    if (cnt_reg < BIT_PHASES)
                    begin
                        clk_next = cnt_reg[0];
                        dio_next = frame_byte[cnt_reg[3:1]];
                    end
                    else
                    begin
                        clk_next = (cnt_reg == ACK_HIGH);
                        dio_next = 1'b0;
                    end
                    if (cnt_reg == ACK_HIGH)
                    begin
                        cnt_next = '0;
                        if (byte_reg == last_byte)
                        begin
                            seg_next = SEG_STOP;
                        end
                        else
                        begin
                            byte_next = byte_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                SEG_STOP:
                begin
                    clk_next = (cnt_reg != '0);
                    dio_next = (cnt_reg == 5'd2);
                    if (cnt_reg == 5'd2)
                    begin
                        seg_next  = SEG_START;
                        cnt_next  = '0;
                        byte_next = '0;
                        if (frame_reg == ssd_pkg::FRAME_CTRL)
                        begin
                            frame_next  = ssd_pkg::FRAME_CMD;
                            active_next = 1'b0;
                            done        = 1'b1;
                        end
                        else
                        begin
                            frame_next = frame_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    seg_next = SEG_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg    <= SEG_START;
            cnt_reg    <= '0;
            byte_reg   <= '0;
            frame_reg  <= ssd_pkg::FRAME_CMD;
            active_reg <= 1'b0;
            clk_reg    <= 1'b1;
            dio_reg    <= 1'b1;
        end
        else
        begin
            seg_reg    <= seg_next;
            cnt_reg    <= cnt_next;
            byte_reg   <= byte_next;
            frame_reg  <= frame_next;
            active_reg <= active_next;
            clk_reg    <= clk_next;
            dio_reg    <= dio_next;
        end
    end

    assign status.busy = active_next;
    assign status.done = done;
    assign status.clk  = clk_next;
    assign status.dio  = dio_next;

    // lines rest high between transfers
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (clk_reg && dio_reg))
        else $error("pins not idle while no transfer runs");

    a_idle_seq: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (seg_reg == SEG_START && cnt_reg == '0 &&
                         frame_reg == ssd_pkg::FRAME_CMD))
        else $error("sequencer not parked while idle");

    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (byte_reg <= last_byte))
        else $error("byte index past end of frame");

endmodule

FILE: hdl/seven_segment_two_wire_display_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_two_wire_display_driver
// stream front end for a two-wire seven-segment led driver
// ----------------------------------------------------------------------------
// Each input transaction (tick, ascii push or raw push) yields exactly one
// result transaction with the clock and data pin levels, busy and a push
// error flag. The block takes one transaction per cycle while the result
// side keeps taking results; each accepted transaction passes the input
// register and then the result register around the single-pass sequencer
// and digit buffer logic. A push marked last that arrives while idle starts a
// transfer of three frames, after which every tick moves the pins by one
// phase. No clearing pass runs after reset.
module seven_segment_two_wire_display_driver #(
    parameter int MAX_DIGITS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        brightness_wr_en,
    input  logic [2:0]  brightness_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // value[7:0], position[10:8], zero
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // clock_pin, data_pin, busy_res, push_error, zero
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [2:0]  brightness_reg;

    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_value_reg;
    logic [2:0]  in_pos_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic        out_clk_reg;
    logic        out_dio_reg;
    logic        out_busy_reg;
    logic        out_err_reg;
    logic        busy_reg;

    logic        move;
    logic        s_accept;
    logic        is_push;
    logic        busy;
    logic        full;
    logic        push_err;

    logic [IDX_W-1:0]      rd_idx;
    logic [7:0]            rd_data;
    logic [CNT_W-1:0]      count;
    logic [2:0]            start_pos;
    ssd_pkg::seq_ctrl_t    seq_ctrl;
    ssd_pkg::seq_status_t  seq_status;

    assign move          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        unique case (in_op_reg) inside
            ssd_pkg::OP_ASCII, ssd_pkg::OP_RAW:
            begin
                is_push = 1'b1;
            end
            default:
            begin
                is_push = 1'b0;
            end
        endcase
    end

    assign seq_ctrl.tick  = move && (in_op_reg == ssd_pkg::OP_TICK);
    assign seq_ctrl.start = move && is_push && !busy && in_last_reg;

    assign push_err = is_push && (busy || full ||
                      ((in_op_reg == ssd_pkg::OP_ASCII) &&
                       !ssd_pkg::char_mapped(in_value_reg)));

    ssd_buffer #(
        .MAX_DIGITS (MAX_DIGITS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (move && is_push && !busy),
        .push_raw  (in_op_reg == ssd_pkg::OP_RAW),
        .value     (in_value_reg),
        .position  (in_pos_reg),
        .clear     (seq_status.done),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .count     (count),
        .start_pos (start_pos),
        .full      (full)
    );

    ssd_seq #(
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (seq_ctrl),
        .brightness (brightness_reg),
        .count      (count),
        .start_pos  (start_pos),
        .rd_data    (rd_data),
        .rd_idx     (rd_idx),
        .status     (seq_status)
    );

    // busy before this transaction is the sequencer's current state
    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (move)
        begin
            busy_reg <= seq_status.busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 3'd7;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (brightness_wr_en)
            begin
                brightness_reg <= brightness_wr_data;
            end
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                in_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg    <= s_axis_tuser;
            in_value_reg <= s_axis_tdata[7:0];
            in_pos_reg   <= s_axis_tdata[10:8];
            in_last_reg  <= s_axis_tlast;
        end
        if (move)
        begin
            out_clk_reg  <= seq_status.clk;
            out_dio_reg  <= seq_status.dio;
            out_busy_reg <= seq_status.busy;
            out_err_reg  <= push_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_err_reg, out_busy_reg, out_dio_reg, out_clk_reg};

    // a push that arrives during a transfer is always flagged
    a_busy_push_err: assert property (@(posedge clk) disable iff (!rst_n)
        (move && is_push && busy) |=> out_err_reg)
        else $error("push during transfer not flagged");

    // a started transfer reports busy on its own result
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_ctrl.start |=> (out_busy_reg && out_valid_reg))
        else $error("transfer start not reported as busy");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stream-level test of the two-wire seven-segment display driver
// ----------------------------------------------------------------------------
// A queue of commands feeds a clocked driver on the input stream. Each
// accepted transaction is run through a cycle-free model of the digit buffer
// and the frame sequencer, and the expected pin levels, busy and error flags
// are queued. A clocked monitor checks every result transaction against the
// oldest expectation. Both sides insert random waits. The brightness level is
// changed between phases, only while the driver is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned DIGIT_SLOTS = 6;
    localparam logic [7:0] HDR_WRITE   = 8'h40;
    localparam logic [7:0] HDR_ADDR    = 8'hC0;
    localparam logic [7:0] HDR_DISPLAY = 8'h88;

    localparam logic [7:0] SEG_FONT [17] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71,
        8'h00
    };

    typedef struct {
        logic [1:0] op;
        logic [7:0] value;
        logic [2:0] pos;
        logic       last;
    } display_cmd_t;

    typedef struct packed {
        logic clk_pin;
        logic dio_pin;
        logic busy;
        logic err;
    } pin_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        brightness_wr_en = 1'b0;
    logic [2:0]  brightness_wr_data = 3'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;   // value[7:0], position[10:8], zero
    logic [1:0]  s_axis_tuser = 2'd0;    // opcode[1:0]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // clock_pin, data_pin, busy_res, push_error, zero

    seven_segment_two_wire_display_driver dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .brightness_wr_en   (brightness_wr_en),
        .brightness_wr_data (brightness_wr_data),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tuser       (s_axis_tuser),
        .s_axis_tlast       (s_axis_tlast),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // display model state
    logic [7:0]  seq_store [DIGIT_SLOTS];
    int unsigned seq_count = 0;
    logic [2:0]  seq_start = 3'd0;
    int unsigned seq_phase = 0;
    logic [1:0]  seq_frame = ssd_pkg::FRAME_CMD;
    logic        seq_active = 1'b0;
    logic        pin_clk = 1'b1;
    logic        pin_dio = 1'b1;
    logic [2:0]  level_bright = 3'd7;

    display_cmd_t outgoing_cmds [$];
    pin_report_t  pending_pins [$];

    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned transfers_started = 0;
    int unsigned pushes_flagged = 0;
    int unsigned fault_count = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_draw = 0;
    logic        send_calm = 1'b0;
    logic        recv_calm = 1'b0;

    function automatic logic [7:0] frame_octet(int unsigned b);
        if (seq_frame == ssd_pkg::FRAME_CMD)
        begin
            return HDR_WRITE;
        end
        if (seq_frame == ssd_pkg::FRAME_CTRL)
        begin
            return HDR_DISPLAY | {5'd0, level_bright};
        end
        if (b == 0)
        begin
            return HDR_ADDR | {5'd0, seq_start};
        end
        return seq_store[b - 1];
    endfunction

    function automatic void step_pin_phase();
        int unsigned nbytes;
        int unsigned body;
        int unsigned p;
        int unsigned q;
        int unsigned r;
        int unsigned s;
        logic [7:0]  cur;
        nbytes = (seq_frame == ssd_pkg::FRAME_DATA) ? 1 + seq_count : 1;
        body = 18 * nbytes;
        p = seq_phase;
        if (p < 2)
        begin
            pin_clk = 1'b1;
            pin_dio = (p == 0);
        end
        else if (p - 2 < body)
        begin
            q = p - 2;
            r = q % 18;
            if (r < 16)
            begin
                cur = frame_octet(q / 18);
                pin_clk = r[0];
                pin_dio = cur[r >> 1];
            end
            else
            begin
                pin_clk = (r == 17);
                pin_dio = 1'b0;
            end
        end
        else
        begin
            s = p - 2 - body;
            pin_clk = (s != 0);
            pin_dio = (s >= 2);
        end
        if (p + 1 >= body + 5)
        begin
            seq_phase = 0;
            if (seq_frame == ssd_pkg::FRAME_CTRL)
            begin
                seq_frame = ssd_pkg::FRAME_CMD;
                seq_active = 1'b0;
                seq_count = 0;
            end
            else
            begin
                seq_frame = seq_frame + 2'd1;
            end
        end
        else
        begin
            seq_phase = p + 1;
        end
    endfunction

    function automatic pin_report_t run_display_model(logic [1:0] op, logic [7:0] val,
                                                       logic [2:0] pos, logic last);
        pin_report_t rep;
        logic        err;
        logic [7:0]  seg;
        err = 1'b0;
        seg = 8'h00;
        if (op == ssd_pkg::OP_TICK)
        begin
            if (seq_active)
            begin
                step_pin_phase();
            end
        end
        else if (op == ssd_pkg::OP_ASCII || op == ssd_pkg::OP_RAW)
        begin
            if (seq_active)
            begin
                err = 1'b1;
            end
            else
            begin
                if (seq_count >= DIGIT_SLOTS)
                begin
                    err = 1'b1;
                end
                else
                begin
                    if (op == ssd_pkg::OP_RAW)
                    begin
                        seg = val;
                    end
                    else if (val >= 8'h30 && val <= 8'h40)
                    begin
                        seg = SEG_FONT[val - 8'h30];
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                    if (seq_count == 0)
                    begin
                        seq_start = pos;
                    end
                    seq_store[seq_count] = seg;
                    seq_count++;
                end
                if (last)
                begin
                    seq_active = 1'b1;
                    seq_frame = ssd_pkg::FRAME_CMD;
                    seq_phase = 0;
                    transfers_started++;
                end
            end
        end
        if (err)
        begin
            pushes_flagged++;
        end
        rep.clk_pin = pin_clk;
        rep.dio_pin = pin_dio;
        rep.busy = seq_active;
        rep.err = err;
        return rep;
    endfunction

    function automatic int unsigned draw_wait(logic calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void log_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // input side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_pins.push_back(run_display_model(s_axis_tuser, s_axis_tdata[7:0],
                                                         s_axis_tdata[10:8], s_axis_tlast));
                items_accepted++;
            end
            if ($urandom_range(0, 39) == 0)
            begin
                send_calm <= !send_calm;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_wait != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (outgoing_cmds.size() != 0)
                begin
                    s_axis_tdata <= {5'd0, outgoing_cmds[0].pos, outgoing_cmds[0].value};
                    s_axis_tuser <= outgoing_cmds[0].op;
                    s_axis_tlast <= outgoing_cmds[0].last;
                    s_axis_tvalid <= 1'b1;
                    send_wait <= draw_wait(send_calm);
                    void'(outgoing_cmds.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                recv_calm <= !recv_calm;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_checked++;
                if (pending_pins.size() == 0)
                begin
                    log_fault($sformatf("result %b with nothing expected", m_axis_tdata[3:0]));
                end
                else if (pending_pins[0].clk_pin !== m_axis_tdata[0]
                         || pending_pins[0].dio_pin !== m_axis_tdata[1]
                         || pending_pins[0].busy !== m_axis_tdata[2]
                         || pending_pins[0].err !== m_axis_tdata[3])
                begin
                    log_fault($sformatf({"mismatch: expected clk %b dio %b busy %b err %b, ",
                                         "got clk %b dio %b busy %b err %b"},
                                        pending_pins[0].clk_pin, pending_pins[0].dio_pin,
                                        pending_pins[0].busy, pending_pins[0].err,
                                        m_axis_tdata[0], m_axis_tdata[1],
                                        m_axis_tdata[2], m_axis_tdata[3]));
                end
                if (pending_pins.size() != 0)
                begin
                    void'(pending_pins.pop_front());
                end
                recv_draw = draw_wait(recv_calm);
                recv_wait <= recv_draw;
                m_axis_tready <= (recv_draw == 0);
            end
            else if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                m_axis_tready <= (recv_wait == 1);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void queue_cmd(logic [1:0] op, logic [7:0] val, logic [2:0] pos,
                                      logic last);
        display_cmd_t c;
        c.op = op;
        c.value = val;
        c.pos = pos;
        c.last = last;
        outgoing_cmds.push_back(c);
        items_queued++;
    endfunction

    function automatic void queue_ticks(int unsigned count);
        repeat (count)
        begin
            queue_cmd(ssd_pkg::OP_TICK, 8'($urandom), 3'($urandom), 1'($urandom));
        end
    endfunction

    // one push sequence followed by ticks, with some noise mixed in
    function automatic int unsigned queue_transfer();
        int unsigned n;
        int unsigned extra;
        int unsigned ticks;
        int unsigned made;
        int unsigned k;
        logic [1:0]  op;
        logic [7:0]  val;
        made = 0;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                queue_cmd($urandom_range(0, 1) ? ssd_pkg::OP_TICK : OP_UNUSED, 8'($urandom),
                          3'($urandom), 1'($urandom));
            end
        end
        n = $urandom_range(1, 6);
        extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        for (k = 0; k < n + extra; k++)
        begin
            op = $urandom_range(0, 1) ? ssd_pkg::OP_ASCII : ssd_pkg::OP_RAW;
            if (op == ssd_pkg::OP_ASCII && $urandom_range(0, 4) != 0)
            begin
                val = 8'($urandom_range(8'h30, 8'h40));
            end
            else
            begin
                val = 8'($urandom);
            end
            queue_cmd(op, val, 3'($urandom),
                      (k == n + extra - 1) && ($urandom_range(0, 11) != 0));
            made++;
        end
        ticks = 69 + 18 * ((n + extra > DIGIT_SLOTS) ? DIGIT_SLOTS : n + extra);
        if ($urandom_range(0, 3) == 0)
        begin
            ticks = $urandom_range(10, ticks);
        end
        repeat (ticks)
        begin
            k = $urandom_range(0, 47);
            if (k < 2)
            begin
                queue_cmd(2'($urandom_range(1, 2)), 8'($urandom), 3'($urandom),
                          1'($urandom));
            end
            else if (k == 2)
            begin
                queue_cmd(OP_UNUSED, 8'($urandom), 3'($urandom), 1'($urandom));
            end
            else
            begin
                queue_cmd(ssd_pkg::OP_TICK, 8'($urandom), 3'($urandom), 1'($urandom));
            end
            made++;
        end
        return made;
    endfunction

    task automatic wait_drained();
        while (items_accepted != items_queued || pending_pins.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // hold the sender until the block is idle and any transfer has finished
    task automatic settle();
        wait_drained();
        while (seq_active)
        begin
            queue_ticks(40);
            wait_drained();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_brightness(logic [2:0] level);
        @(posedge clk);
        brightness_wr_en <= 1'b1;
        brightness_wr_data <= level;
        @(posedge clk);
        brightness_wr_en <= 1'b0;
        level_bright = level;
    endtask

    task automatic run_random_phase(int unsigned quota);
        int unsigned made;
        made = 0;
        while (made < quota)
        begin
            made += queue_transfer();
        end
        settle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle behavior, then a buffer filled with edge-case characters
        queue_cmd(ssd_pkg::OP_TICK, 8'hFF, 3'd7, 1'b1);
        queue_cmd(OP_UNUSED, 8'hFF, 3'd7, 1'b1);
        queue_cmd(ssd_pkg::OP_ASCII, 8'h30, 3'd7, 1'b0);
        queue_cmd(ssd_pkg::OP_ASCII, 8'h40, 3'd0, 1'b0);
        queue_cmd(ssd_pkg::OP_ASCII, 8'h2F, 3'd2, 1'b0);
        queue_cmd(ssd_pkg::OP_ASCII, 8'hFF, 3'd5, 1'b0);
        queue_cmd(ssd_pkg::OP_RAW, 8'h00, 3'd6, 1'b0);
        queue_cmd(ssd_pkg::OP_RAW, 8'hFF, 3'd1, 1'b0);
        queue_cmd(ssd_pkg::OP_RAW, 8'hA5, 3'd3, 1'b0);
        queue_cmd(ssd_pkg::OP_ASCII, 8'h39, 3'd4, 1'b1);
        queue_cmd(ssd_pkg::OP_ASCII, 8'h31, 3'd0, 1'b1);
        queue_cmd(ssd_pkg::OP_RAW, 8'h5A, 3'd0, 1'b0);
        queue_cmd(OP_UNUSED, 8'h00, 3'd0, 1'b0);
        queue_ticks(180);
        queue_cmd(ssd_pkg::OP_ASCII, 8'h41, 3'd5, 1'b0);
        queue_cmd(ssd_pkg::OP_RAW, 8'h80, 3'd0, 1'b1);
        queue_ticks(110);
        queue_cmd(ssd_pkg::OP_ASCII, 8'h3F, 3'd0, 1'b1);
        queue_ticks(20);
        settle();

        set_brightness(3'd0);
        run_random_phase(50);
        set_brightness(3'd3);
        run_random_phase(50);
        set_brightness(3'd7);
        run_random_phase(50);
        set_brightness(3'($urandom));
        run_random_phase(50);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("ran %0d input transactions and checked %0d results", items_accepted,
                 results_checked);
        $display("%0d transfers started, %0d pushes flagged", transfers_started,
                 pushes_flagged);
        if (fault_count == 0)
        begin
            $display("seven_segment_two_wire_display_driver test passed");
        end
        else
        begin
            $display("seven_segment_two_wire_display_driver test failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("seven_segment_two_wire_display_driver test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ssd_pkg.sv
hdl/ssd_buffer.sv
hdl/ssd_seq.sv
hdl/seven_segment_two_wire_display_driver.sv
sim/tb.sv
